FILE: rtl/core/efd_pkg.sv
// Shared types and constants for the escaped frame deframer.
package efd_pkg;

  // Receive buffer size; a frame is dropped once its raw count reaches half of it
  localparam int BUFFER_BYTES = 1024;
  localparam int HALF_BYTES   = BUFFER_BYTES / 2;
  localparam int CNT_W        = $clog2(HALF_BYTES + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END    = 1'd1;

  localparam logic [7:0] ESCAPE_RESET = 8'd125;
  localparam logic [7:0] END_RESET    = 8'd126;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_TYPE     = 3'd0,
    KIND_PAYLOAD  = 3'd1,
    KIND_OK       = 3'd2,
    KIND_BAD      = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_t;

  // Active framing bytes
  typedef struct packed {
    logic [7:0] escape_byte;
    logic [7:0] end_byte;
  } cfg_t;

  // Decoded result for one byte
  typedef struct packed {
    logic       have;
    kind_t      kind;
    logic [7:0] value;
    logic       last;
  } res_t;

endpackage

FILE: rtl/core/efd_cfg_regs.sv
// Configuration registers holding the escape and end byte values.
module efd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [efd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output efd_pkg::cfg_t                 cfg
);

  // Write decode; reset restores the default framing bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.escape_byte <= efd_pkg::ESCAPE_RESET;
      cfg.end_byte    <= efd_pkg::END_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        efd_pkg::REG_ESCAPE: cfg.escape_byte <= cfg_data;
        efd_pkg::REG_END:    cfg.end_byte    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/efd_frame_decoder.sv
// Frame state and per-byte unstuffing decision.
module efd_frame_decoder (
  input  logic          clk,
  input  logic          rst,
  input  efd_pkg::cfg_t cfg,
  input  logic          step,
  input  logic [7:0]    data,
  output efd_pkg::res_t res
);

  logic                      escape_pending;
  logic                      escape_pending_next;
  logic [efd_pkg::CNT_W-1:0] raw_count;
  logic [efd_pkg::CNT_W-1:0] raw_count_next;
  logic                      bad_escape_seen;
  logic                      bad_escape_seen_next;
  logic [efd_pkg::CNT_W-1:0] count_inc;
  logic                      have;
  logic                      close;
  efd_pkg::kind_t            kind;

  assign count_inc = raw_count + efd_pkg::CNT_W'(1);

  // Classify the byte against the frame state
  always_comb begin
    have                 = 1'b0;
    close                = 1'b0;
    kind                 = efd_pkg::KIND_TYPE;
    escape_pending_next  = escape_pending;
    bad_escape_seen_next = bad_escape_seen;
    if (raw_count == '0) begin
      have = 1'b1;
    end else if (escape_pending) begin
      escape_pending_next = 1'b0;
      if (data == cfg.escape_byte || data == cfg.end_byte) begin
        have = 1'b1;
        kind = efd_pkg::KIND_PAYLOAD;
      end else begin
        bad_escape_seen_next = 1'b1;
      end
    end else if (data == cfg.end_byte) begin
      close = 1'b1;
    end else if (data == cfg.escape_byte) begin
      escape_pending_next = 1'b1;
    end else begin
      have = 1'b1;
      kind = efd_pkg::KIND_PAYLOAD;
    end

    raw_count_next = count_inc;
    res.have       = have;
    res.kind       = kind;
    res.value      = data;
    res.last       = 1'b0;

    // Frame end wins over overflow; both return the frame to idle
    if (close) begin
      res.have  = 1'b1;
      res.kind  = bad_escape_seen ? efd_pkg::KIND_BAD : efd_pkg::KIND_OK;
      res.value = '0;
      res.last  = 1'b1;
    end else if (count_inc == efd_pkg::CNT_W'(efd_pkg::HALF_BYTES)) begin
      res.have  = 1'b1;
      res.kind  = efd_pkg::KIND_OVERFLOW;
      res.value = '0;
      res.last  = 1'b1;
    end
    if (res.last) begin
      escape_pending_next  = 1'b0;
      bad_escape_seen_next = 1'b0;
      raw_count_next       = '0;
    end
  end

  // Frame state, updated once per processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending  <= 1'b0;
      raw_count       <= '0;
      bad_escape_seen <= 1'b0;
    end else if (step) begin
      escape_pending  <= escape_pending_next;
      raw_count       <= raw_count_next;
      bad_escape_seen <= bad_escape_seen_next;
    end
  end

  // Count stays below the drop threshold
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    raw_count < efd_pkg::CNT_W'(efd_pkg::HALF_BYTES))
    else $error("raw count reached drop threshold");

  // A closing or dropping byte leaves the frame idle
  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    step && res.last |=> raw_count == '0 && !escape_pending && !bad_escape_seen)
    else $error("frame state not cleared after close");

  // No escape is pending while no frame is open
  a_idle_no_escape: assert property (@(posedge clk) disable iff (rst)
    raw_count == '0 |-> !escape_pending && !bad_escape_seen)
    else $error("escape state set outside a frame");

endmodule

FILE: rtl/core/escaped_frame_deframer.sv
// Top level of the escaped frame deframer: input register, decoder, result register.
//
// Strips escape stuffing from a received byte stream. The first byte of each frame is
// passed on as the type, later bytes as payload with escapes removed; an unescaped end
// byte closes the frame (ok or bad escape), and a frame reaching half of BUFFER_BYTES raw
// bytes is dropped with an overflow result. One byte is taken every cycle while
// byte_stall is low; the decoder works on the input register and its outcome is loaded
// into the result register once that register is free, together with the frame state
// update. Bytes that produce no result (an escape, or an invalid escape pair) still pass
// through the input register and update the frame state. The user must write escape and
// end byte values only while no bytes are in flight; the block itself does not enforce this.
module escaped_frame_deframer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [efd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          byte_valid,
  output logic                          byte_stall,
  input  logic [7:0]                    data_byte,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [2:0]                    kind,
  output logic [7:0]                    value,
  output logic                          last
);

  efd_pkg::cfg_t cfg;
  efd_pkg::res_t res;
  logic          hold_valid;
  logic [7:0]    hold_byte;
  logic          step;

  efd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  efd_frame_decoder u_dec (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (step),
    .data (hold_byte),
    .res  (res)
  );

  // Held byte is processed once the result register is free
  assign step       = hold_valid && (!result_valid || !result_stall);
  assign byte_stall = hold_valid && !step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!byte_stall) begin
      hold_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      hold_byte <= data_byte;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step) begin
      result_valid <= res.have;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      kind  <= res.kind;
      value <= res.value;
      last  <= res.last;
    end
  end

  // last marks exactly the frame end and drop kinds
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (last == (kind == efd_pkg::KIND_OK || kind == efd_pkg::KIND_BAD ||
                               kind == efd_pkg::KIND_OVERFLOW)))
    else $error("last does not match result kind");

  // Frame end and drop carry no byte
  a_last_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> value == 8'd0)
    else $error("closing result carries a byte");

  // A full input register behind a stalled result blocks new bytes
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    hold_valid && result_valid && result_stall |-> byte_stall && !step)
    else $error("byte taken while pipeline is blocked");

endmodule
